[hdl/bffca_pkg.sv]
package bffca_pkg;

   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 11;
   localparam int RES_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam int PAGE_BYTES          = 4096;
   localparam int NUM_CHUNKS_DEF      = 64;
   localparam int PAGES_PER_CHUNK_DEF = 16;

   localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = 32'hC000_0000;
   localparam logic [RES_W-1:0]  RESERVED_RESET     = '0;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDRESS    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_RESERVED_CHUNKS = 1'b1;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad;
      logic hit;
      logic last;
   } dp_status_type;

endpackage

[hdl/bffca_ctrl.sv]
module bffca_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   output bffca_pkg::ctrl_cmd_type  cmd,
   input  bffca_pkg::dp_status_type status
);
   import bffca_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      done_ff;

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && start;
      cmd.step   = (state_ff == ST_SCAN);
      cmd.finish = (state_ff == ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_SCAN;
                  busy_ff  <= 1'b1;
               end
            end
            ST_SCAN: begin
               if (status.bad || status.hit || status.last) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
               done_ff  <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = done_ff;

endmodule

[hdl/bffca_dpath.sv]
module bffca_dpath #(
   parameter int NUM_CHUNKS      = bffca_pkg::NUM_CHUNKS_DEF,
   parameter int PAGES_PER_CHUNK = bffca_pkg::PAGES_PER_CHUNK_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bffca_pkg::ctrl_cmd_type             cmd,
   output bffca_pkg::dp_status_type            status,
   input  logic                                req_command,
   input  logic [bffca_pkg::SIZE_W-1:0]        req_size_pages,
   input  logic [bffca_pkg::ADDR_W-1:0]        req_address,
   output logic                                rsp_status,
   output logic [bffca_pkg::ADDR_W-1:0]        rsp_result_address,
   input  logic                                csr_write_enable,
   input  logic [bffca_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bffca_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import bffca_pkg::*;

   localparam int CW     = $clog2(NUM_CHUNKS);
   localparam int RUN_MAX = NUM_CHUNKS * PAGES_PER_CHUNK;
   localparam int RUN_W  = ($clog2(RUN_MAX + 1) > SIZE_W) ? $clog2(RUN_MAX + 1) : SIZE_W;
   localparam logic [ADDR_W-1:0] CHUNK_BYTES = ADDR_W'(PAGES_PER_CHUNK * PAGE_BYTES);
   localparam logic [ADDR_W-1:0] WINDOW      = ADDR_W'(NUM_CHUNKS * PAGES_PER_CHUNK * PAGE_BYTES);
   localparam logic [CW-1:0]     LAST_IDX    = CW'(NUM_CHUNKS - 1);
   localparam logic [RUN_W:0]    PPC_RUN     = (RUN_W+1)'(PAGES_PER_CHUNK);
   localparam logic [SIZE_W-1:0] PPC_SIZE    = SIZE_W'(PAGES_PER_CHUNK);

   // configuration
   logic [ADDR_W-1:0]     base_ff;
   logic [RES_W-1:0]      reserved_ff;

   // allocation state
   logic [NUM_CHUNKS-1:0] used_ff;

   // per-item working registers
   command_type           command_ff;
   logic [SIZE_W-1:0]     pages_ff;
   logic [ADDR_W-1:0]     address_ff;
   logic [CW-1:0]         idx_ff;
   logic [ADDR_W-1:0]     bound_ff;
   logic [RUN_W-1:0]      run_pages_ff;
   logic [CW-1:0]         run_start_ff;
   logic [ADDR_W-1:0]     run_off_ff;
   logic [CW-1:0]         end_idx_ff;
   logic                  found_ff;
   logic [SIZE_W-1:0]     rem_ff;

   logic [ADDR_W-1:0]     offset;
   logic [ADDR_W-1:0]     next_bound;
   logic                  reserved_here;
   logic                  taken;
   logic [RUN_W:0]        run_sum;
   logic                  bad;
   logic                  hit;
   logic                  in_run;
   logic [NUM_CHUNKS-1:0] run_mask;
   logic                  success;

   always_comb begin
      offset        = address_ff - base_ff;
      next_bound    = bound_ff + CHUNK_BYTES;
      reserved_here = RES_W'(idx_ff) < reserved_ff;
      taken         = used_ff[idx_ff] || reserved_here;
      run_sum       = {1'b0, run_pages_ff} + PPC_RUN;
      bad           = (pages_ff == '0) || ((command_ff == CMD_FREE) && (offset >= WINDOW));
      hit           = (command_ff == CMD_ALLOC) && !bad && !taken &&
                      (run_sum >= (RUN_W+1)'(pages_ff));
      in_run        = (next_bound > offset) && (rem_ff != '0);
      success       = (command_ff == CMD_FREE) ? !bad : found_ff;
      for (int j = 0; j < NUM_CHUNKS; j++) begin
         run_mask[j] = (CW'(j) >= run_start_ff) && (CW'(j) <= end_idx_ff);
      end
      status.bad  = bad;
      status.hit  = hit;
      status.last = (idx_ff == LAST_IDX);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= BASE_ADDRESS_RESET;
         reserved_ff <= RESERVED_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_BASE_ADDRESS:    base_ff     <= csr_write_data[ADDR_W-1:0];
            REG_RESERVED_CHUNKS: reserved_ff <= csr_write_data[RES_W-1:0];
            default: ;
         endcase
      end
   end

   // used map
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.step && !bad && (command_ff == CMD_FREE)) begin
         if (in_run && !reserved_here) begin
            used_ff[idx_ff] <= 1'b0;
         end
      end else if (cmd.finish && (command_ff == CMD_ALLOC) && found_ff) begin
         used_ff <= used_ff | run_mask;
      end
   end

   // scan registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff   <= command_type'(req_command);
         pages_ff     <= req_size_pages;
         address_ff   <= req_address;
         idx_ff       <= '0;
         bound_ff     <= '0;
         run_pages_ff <= '0;
         run_start_ff <= '0;
         run_off_ff   <= '0;
         end_idx_ff   <= '0;
         found_ff     <= 1'b0;
         rem_ff       <= req_size_pages;
      end else if (cmd.step) begin
         idx_ff   <= idx_ff + 1'b1;
         bound_ff <= next_bound;
         if (taken) begin
            run_pages_ff <= '0;
            run_start_ff <= idx_ff + 1'b1;
            run_off_ff   <= next_bound;
         end else begin
            run_pages_ff <= run_sum[RUN_W-1:0];
         end
         if (hit) begin
            found_ff   <= 1'b1;
            end_idx_ff <= idx_ff;
         end
         if (in_run) begin
            rem_ff <= (rem_ff > PPC_SIZE) ? (rem_ff - PPC_SIZE) : '0;
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status <= success ? STATUS_OK : STATUS_FAIL;
         rsp_result_address <= (success && (command_ff == CMD_ALLOC)) ?
                               (base_ff + run_off_ff) : '0;
      end
   end

endmodule

[hdl/bitmap_first_fit_chunk_allocator_unit.sv]
// Chunk allocator over a window of NUM_CHUNKS chunks of PAGES_PER_CHUNK 4 KiB pages
// above base_address, with one used bit per chunk. Pulse start while busy is low
// to hand in an item: an allocate finds the lowest free run long enough for the
// page count and returns its address, a free clears the chunks covered by address
// and size. The result shows on rsp_status and rsp_result_address for exactly one
// cycle with rsp_valid high, and it cannot be held off, so take it when it comes.
// The scan walks one chunk per cycle: an allocate stops at the chunk that ends
// the winning run, or at the last chunk if none fits, a free always walks every
// chunk, and a zero size or an out-of-window free stops at the first. busy falls
// in the cycle rsp_valid rises, and the next item may be started in that cycle.
// Write csr registers only while busy is low and no result is pending.
module bitmap_first_fit_chunk_allocator_unit #(
   parameter int NUM_CHUNKS      = bffca_pkg::NUM_CHUNKS_DEF,
   parameter int PAGES_PER_CHUNK = bffca_pkg::PAGES_PER_CHUNK_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // item in
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_command,
   input  logic [bffca_pkg::SIZE_W-1:0]     req_size_pages,
   input  logic [bffca_pkg::ADDR_W-1:0]     req_address,
   // result out, one-cycle strobe
   output logic                             rsp_valid,
   output logic                             rsp_status,
   output logic [bffca_pkg::ADDR_W-1:0]     rsp_result_address,
   // register writes
   input  logic                             csr_write_enable,
   input  logic [bffca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bffca_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import bffca_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: idle, chunk scan, finish
   bffca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // used map, config registers, run tracking and result registers
   bffca_dpath #(
      .NUM_CHUNKS      (NUM_CHUNKS),
      .PAGES_PER_CHUNK (PAGES_PER_CHUNK)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_command        (req_command),
      .req_size_pages     (req_size_pages),
      .req_address        (req_address),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

`ifndef SYNTH
   // an accepted item keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // a result only follows work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding busy cycle");

   // each result is shown once
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // failures carry a zero address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FAIL)) |-> (rsp_result_address == '0))
      else $error("failed item returned a nonzero address");
`endif

endmodule

[dv/tb.sv]
module tb;
   import bffca_pkg::*;

   // window geometry at the default build
   localparam int                CHUNKS       = NUM_CHUNKS_DEF;
   localparam logic [ADDR_W-1:0] CHUNK_BYTES  = PAGES_PER_CHUNK_DEF * PAGE_BYTES;
   localparam logic [ADDR_W-1:0] WINDOW_BYTES = CHUNK_BYTES * CHUNKS;
   localparam int                MAX_PAGES    = CHUNKS * PAGES_PER_CHUNK_DEF;

   // a full scan plus a little margin
   localparam int SETTLE_CYCLES = CHUNKS + 8;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASE_ITEMS   = 250;

   typedef struct {
      logic              status;
      logic [ADDR_W-1:0] addr;
   } reply_type;

   // an allocation that is believed to be live, kept so frees hit real runs
   typedef struct {
      logic [ADDR_W-1:0] addr;
      int                pages;
   } alloc_run_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_command = 1'b0;
   logic [SIZE_W-1:0]     req_size_pages = '0;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  rsp_valid;
   logic                  rsp_status;
   logic [ADDR_W-1:0]     rsp_result_address;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   // predicted allocator state and registers
   logic [CHUNKS-1:0] chunk_used     = '0;
   logic [ADDR_W-1:0] window_base    = BASE_ADDRESS_RESET;
   logic [RES_W-1:0]  reserved_count = RESERVED_RESET;

   reply_type     pending_replies[$];
   alloc_run_type live_runs[$];
   int            error_count = 0;
   int            cycle_count = 0;
   bit            quiet_phase = 1'b0;

   bitmap_first_fit_chunk_allocator_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_size_pages     (req_size_pages),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies pending", cycle_count,
                  pending_replies.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic [CHUNKS-1:0] low_ones(input int n);
      if (n >= CHUNKS) return '1;
      return (CHUNKS'(1) << n) - CHUNKS'(1);
   endfunction

   // first-fit allocate or free against the predicted map
   function automatic void predict_reply(input command_type cmd, input int pages,
                                         input logic [ADDR_W-1:0] addr,
                                         output reply_type reply);
      logic [CHUNKS-1:0] res_mask;
      logic [CHUNKS-1:0] taken;
      logic [CHUNKS-1:0] span;
      logic [ADDR_W-1:0] offset;
      int                n;
      int                first;
      int                last;
      int                rcount;
      reply.status = STATUS_FAIL;
      reply.addr   = '0;
      // a reserved count beyond the window saturates at the window size
      rcount   = (reserved_count > CHUNKS) ? CHUNKS : int'(reserved_count);
      res_mask = low_ones(rcount);
      n        = (pages + PAGES_PER_CHUNK_DEF - 1) / PAGES_PER_CHUNK_DEF;
      if (pages == 0) return;
      if (cmd == CMD_ALLOC) begin
         if (n <= CHUNKS) begin
            taken = chunk_used | res_mask;
            for (int s = 0; s + n <= CHUNKS; s++) begin
               span = low_ones(n) << s;
               if ((taken & span) == '0) begin
                  chunk_used   = chunk_used | span;
                  reply.status = STATUS_OK;
                  // address arithmetic wraps at 32 bits
                  reply.addr   = window_base + CHUNK_BYTES * s;
                  break;
               end
            end
         end
      end else begin
         offset = addr - window_base;
         if (offset < WINDOW_BYTES) begin
            // unaligned start rounds down, the tail clips at the window end
            first = offset / CHUNK_BYTES;
            last  = first + n;
            if (last > CHUNKS) last = CHUNKS;
            span         = low_ones(last) & ~low_ones(first);
            chunk_used   = chunk_used & ~(span & ~res_mask);
            reply.status = STATUS_OK;
         end
      end
   endfunction

   // hand one item over, leaves start high so a back-to-back item can follow
   task automatic send_item(input command_type cmd, input int pages,
                            input logic [ADDR_W-1:0] addr);
      reply_type     reply;
      alloc_run_type run;
      start          <= 1'b1;
      req_command    <= cmd;
      req_size_pages <= pages[SIZE_W-1:0];
      req_address    <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      predict_reply(cmd, pages, addr, reply);
      pending_replies.push_back(reply);
      if (cmd == CMD_ALLOC && reply.status == STATUS_OK) begin
         run.addr  = reply.addr;
         run.pages = pages;
         live_runs.push_back(run);
      end
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // mostly back to back or short, now and then a long gap
   function automatic int random_gap();
      int pick;
      if (quiet_phase) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   task automatic wait_for_replies();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers, back to back; only while the block is idle
   task automatic set_window(input logic [ADDR_W-1:0] base, input int resv);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_BASE_ADDRESS;
      csr_write_data   <= base;
      @(posedge clock);
      window_base = base;
      live_runs.delete();
      csr_index      <= REG_RESERVED_CHUNKS;
      csr_write_data <= CSR_DATA_W'(resv[RES_W-1:0]);
      @(posedge clock);
      reserved_count = resv[RES_W-1:0];
      csr_write_enable <= 1'b0;
   endtask

   // check every reply strobe against the oldest prediction
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("reply with nothing pending: status %0b addr %08h",
                                      rsp_status, rsp_result_address));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0b, predicted %0b",
                                         rsp_status, want.status));
            if (rsp_result_address !== want.addr)
               report_mismatch($sformatf("address %08h, predicted %08h",
                                         rsp_result_address, want.addr));
         end
      end
   end

   // default window: zero sizes, first fit, unaligned and clipped frees
   task automatic test_alloc_free_basics();
      logic [ADDR_W-1:0] b;
      b = BASE_ADDRESS_RESET;
      send_item(CMD_ALLOC, 0, '0);
      send_item(CMD_ALLOC, 1, '0);
      pause_sender(random_gap());
      send_item(CMD_ALLOC, PAGES_PER_CHUNK_DEF, 32'hFFFF_FFFF);
      send_item(CMD_ALLOC, PAGES_PER_CHUNK_DEF + 1, '0);
      // too large for what is left
      send_item(CMD_ALLOC, MAX_PAGES, '0);
      pause_sender(random_gap());
      send_item(CMD_FREE, 0, b);
      // one byte below the window and the first byte past it
      send_item(CMD_FREE, PAGES_PER_CHUNK_DEF, b - 1);
      send_item(CMD_FREE, PAGES_PER_CHUNK_DEF, b + WINDOW_BYTES);
      // unaligned free, then the same chunk again while already free
      send_item(CMD_FREE, 1, b + CHUNK_BYTES + 32'h1234);
      pause_sender(random_gap());
      send_item(CMD_FREE, 1, b + CHUNK_BYTES + 32'h1234);
      // runs past the end of the window
      send_item(CMD_FREE, MAX_PAGES, b + WINDOW_BYTES - CHUNK_BYTES);
      send_item(CMD_FREE, 3 * PAGES_PER_CHUNK_DEF, b);
      send_item(CMD_ALLOC, 60 * PAGES_PER_CHUNK_DEF, '0);
      send_item(CMD_FREE, MAX_PAGES, b);
      pause_sender(random_gap());
      send_item(CMD_ALLOC, MAX_PAGES, '0);
      // map is full now
      send_item(CMD_ALLOC, 1, '0);
   endtask

   // window across the top of the address space and reserved chunks
   task automatic test_wrap_and_reserved();
      wait_for_replies();
      set_window(32'hFFFE_0000, 3);
      send_item(CMD_FREE, MAX_PAGES, 32'hFFFE_0000);
      send_item(CMD_ALLOC, PAGES_PER_CHUNK_DEF, '0);
      // covers reserved chunks, which stay used
      send_item(CMD_FREE, 4 * PAGES_PER_CHUNK_DEF, 32'hFFFE_0000);
      send_item(CMD_ALLOC, 1, '0);
      // last byte of the window, then one past it
      send_item(CMD_FREE, PAGES_PER_CHUNK_DEF, 32'h003D_FFFF);
      send_item(CMD_FREE, PAGES_PER_CHUNK_DEF, 32'h003E_0000);
      // everything reserved
      wait_for_replies();
      set_window('0, CHUNKS);
      send_item(CMD_ALLOC, 1, '0);
      send_item(CMD_FREE, MAX_PAGES, '0);
      // reserved count beyond the window
      wait_for_replies();
      set_window('0, 127);
      send_item(CMD_ALLOC, 1, '0);
      wait_for_replies();
      set_window('0, 0);
      send_item(CMD_ALLOC, MAX_PAGES, '0);
      send_item(CMD_FREE, MAX_PAGES, '0);
   endtask

   function automatic int random_alloc_pages();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 4 * PAGES_PER_CHUNK_DEF);
      if (pick < 90) return $urandom_range(4 * PAGES_PER_CHUNK_DEF + 1, 256);
      if (pick < 98) return $urandom_range(257, MAX_PAGES - 1);
      return MAX_PAGES;
   endfunction

   // mostly allocations and frees of live runs, the rest noise
   task automatic send_random_item();
      int            pick;
      int            idx;
      alloc_run_type run;
      pick = $urandom_range(0, 99);
      if (live_runs.size() == 0 && pick < 85) pick = 0;
      if (pick < 45) begin
         send_item(CMD_ALLOC, random_alloc_pages(), $urandom);
      end else if (pick < 85) begin
         idx = $urandom_range(0, live_runs.size() - 1);
         run = live_runs[idx];
         live_runs.delete(idx);
         if ($urandom_range(0, 3) != 0)
            send_item(CMD_FREE, run.pages, run.addr);
         else
            // partial or oversized, unaligned inside the first chunk
            send_item(CMD_FREE, $urandom_range(1, MAX_PAGES),
                      run.addr + $urandom_range(0, CHUNK_BYTES - 1));
      end else begin
         case ($urandom_range(0, 3))
            0: send_item(command_type'($urandom_range(0, 1)), 0, $urandom);
            1: send_item(CMD_FREE, $urandom_range(0, MAX_PAGES), $urandom);
            2: send_item(CMD_FREE, $urandom_range(1, MAX_PAGES),
                         window_base + $urandom_range(0, WINDOW_BYTES - 1));
            default: send_item(CMD_ALLOC, $urandom_range(257, MAX_PAGES), $urandom);
         endcase
      end
   endtask

   // one phase per register setting, map carried over between phases
   task automatic test_random_traffic();
      int count;
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_replies();
         count = PHASE_ITEMS;
         case (phase)
            0: set_window(BASE_ADDRESS_RESET, 0);
            1: set_window($urandom, $urandom_range(0, 8));
            2: set_window(32'hFFE0_0000, 1);
            3: set_window($urandom, $urandom_range(0, CHUNKS));
            4: begin
               // all allocations fail here, keep it short
               set_window(32'hFFFF_FFFF, 100);
               count = 60;
            end
            default: set_window($urandom, 0);
         endcase
         quiet_phase = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < count; i++) begin
            send_random_item();
            pause_sender(random_gap());
         end
      end
      quiet_phase = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_alloc_free_basics();
      test_wrap_and_reserved();
      test_random_traffic();
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[bitmap_first_fit_chunk_allocator_unit.f]
hdl/bffca_pkg.sv
hdl/bffca_ctrl.sv
hdl/bffca_dpath.sv
hdl/bitmap_first_fit_chunk_allocator_unit.sv
dv/tb.sv
